[rtl/euler_axis_rotation_sequence_defines.svh]
// ----------------------------------------------------------------------------
// euler_axis_rotation_sequence_defines.svh
// Assertion macros shared by the rotation sequencer checks.
// ----------------------------------------------------------------------------
`ifndef EULER_AXIS_ROTATION_SEQUENCE_DEFINES_SVH
`define EULER_AXIS_ROTATION_SEQUENCE_DEFINES_SVH

// same-cycle implication
`define EARS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EARS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ears_pkg.sv]
// ----------------------------------------------------------------------------
// ears_pkg
// Shared types, constants and tables of the Euler axis rotation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ears_pkg;

  localparam int EARS_DEF_MAX_STEPS    = 3;
  localparam int EARS_DEF_CORDIC_ITER  = 16;
  localparam int EARS_DEF_VECTOR_WIDTH = 32;

  localparam int ITER_IDX_W = 5;
  localparam int CORDIC_W   = 34;
  localparam int MIX_W      = 3;

  // 0.6072529350 in Q2.30
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  // atan(2^-i), 2^31 = pi
  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_END = 2'd3
  } axis_code_t;

  typedef struct packed {
    logic                  load;
    logic                  cinit;
    logic                  citer;
    logic                  cfin;
    logic                  mul;
    logic                  wb;
    logic                  rload;
    logic [1:0]            step;
    logic [ITER_IDX_W-1:0] iter;
    logic [MIX_W-1:0]      mix;
  } ears_cmd_t;

  typedef struct packed {
    axis_code_t code;
  } ears_status_t;

endpackage

`default_nettype wire

[rtl/ears_ctrl.sv]
// ----------------------------------------------------------------------------
// ears_ctrl
// Sequencer: walks the axis codes, runs the CORDIC, the product schedule
// and the write-back, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ears_ctrl import ears_pkg::*; #(
  parameter int MAX_STEPS         = EARS_DEF_MAX_STEPS,
  parameter int CORDIC_ITERATIONS = EARS_DEF_CORDIC_ITER
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ears_cmd_t         cmd,
  input  wire ears_status_t status
);

  localparam int NSTEP = (MAX_STEPS < 3) ? MAX_STEPS : 3;
  localparam int IW    = $clog2(CORDIC_ITERATIONS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INIT,
    S_ITER,
    S_FIN,
    S_MUL,
    S_DRAIN,
    S_WB,
    S_DONE
  } state_t;

  state_t           state;
  logic [1:0]       step;
  logic [IW-1:0]    iter;
  logic [MIX_W-1:0] mix;
  logic             take;
  logic             slot_free;

  assign in_stall  = (state != S_IDLE);
  assign take      = in_valid && (state == S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd       = '0;
    cmd.step  = step;
    cmd.iter  = ITER_IDX_W'(iter);
    cmd.mix   = mix;
    cmd.load  = take;
    cmd.cinit = (state == S_INIT);
    cmd.citer = (state == S_ITER);
    cmd.cfin  = (state == S_FIN);
    cmd.mul   = (state == S_MUL);
    cmd.wb    = (state == S_WB);
    cmd.rload = (state == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      iter      <= '0;
      mix       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.rload) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            step  <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((step == 2'(NSTEP)) || (status.code == AXIS_END)) begin
            state <= S_DONE;
          end else begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          iter  <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (iter == IW'(CORDIC_ITERATIONS - 1)) begin
            state <= S_FIN;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        S_FIN: begin
          mix   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          mix <= mix + 1'b1;
          if (mix == '1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          mix <= mix + 1'b1;
          if (mix == MIX_W'(1)) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          step  <= step + 1'b1;
          state <= S_CHECK;
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ears_dp.sv]
// ----------------------------------------------------------------------------
// ears_dp
// Datapath: component registers, CORDIC sine/cosine unit, shared multiplier
// with rounding and accumulation, saturation and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ears_dp import ears_pkg::*; #(
  parameter int VECTOR_WIDTH = EARS_DEF_VECTOR_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ears_cmd_t          cmd,
  output ears_status_t            status,
  input  wire logic               mode,
  input  wire logic signed [31:0] vec_x,
  input  wire logic signed [31:0] vec_y,
  input  wire logic signed [31:0] vec_z,
  input  wire logic signed [15:0] angle_x,
  input  wire logic signed [15:0] angle_y,
  input  wire logic signed [15:0] angle_z,
  input  wire logic [5:0]         axis_order,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [1:0]              steps_applied
);

  localparam int VW = VECTOR_WIDTH;
  localparam int EW = (VW > 32) ? VW : 32;
  localparam int HW = EW - 16;
  localparam int MA = HW + 1;
  localparam int PW = MA + 32;
  localparam int AW = EW + 33;
  localparam int RW = EW + 1;
  localparam int SW = EW + 2;
  localparam int CW = CORDIC_W;

  localparam logic signed [SW-1:0] VMAX = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = ~VMAX;
  localparam logic signed [SW-1:0] OMAX = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] OMIN = ~OMAX;
  localparam logic signed [AW-1:0] RND_HALF = {{(AW-30){1'b0}}, 1'b1, 29'd0};

  function automatic logic signed [VW-1:0] sat_vw(input logic signed [SW-1:0] a);
    logic signed [VW-1:0] r;
    if (a > VMAX) begin
      r = VMAX[VW-1:0];
    end else if (a < VMIN) begin
      r = VMIN[VW-1:0];
    end else begin
      r = a[VW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [VW-1:0] v);
    logic signed [SW-1:0] a;
    logic signed [31:0]   r;
    a = SW'(v);
    if (a > OMAX) begin
      r = OMAX[31:0];
    end else if (a < OMIN) begin
      r = OMIN[31:0];
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  // item registers
  logic                 vmode;
  logic [5:0]           order;
  logic signed [15:0]   ax, ay, az;
  logic signed [VW-1:0] vx, vy, vz;

  // CORDIC unit
  logic signed [CW-1:0] cx, cy, cz;
  logic                 flip;
  logic signed [31:0]   cosv, sinv;

  // step operands and products
  logic signed [VW-1:0] vp, vq;
  logic signed [PW-1:0] prod;
  logic [MIX_W-1:0]     ptag;
  logic                 pvld;
  logic signed [AW-1:0] acc;
  logic signed [RW-1:0] rnd;
  logic [1:0]           rtag;
  logic                 rvld;
  logic signed [SW-1:0] np, nq;

  axis_code_t code;

  always_comb begin
    unique case (cmd.step)
      2'd0:    code = axis_code_t'(order[1:0]);
      2'd1:    code = axis_code_t'(order[3:2]);
      2'd2:    code = axis_code_t'(order[5:4]);
      default: code = AXIS_END;
    endcase
  end

  assign status.code = code;

  // angle range reduction
  logic signed [15:0] asel;
  logic signed [16:0] a17, ared;
  logic signed [32:0] zi;
  logic               aflip;

  always_comb begin
    unique case (code)
      AXIS_X:   asel = ax;
      AXIS_Y:   asel = ay;
      AXIS_Z:   asel = az;
      AXIS_END: asel = ax;
    endcase
    a17   = 17'(asel);
    aflip = 1'b0;
    ared  = a17;
    if (a17 > 17'sd16384) begin
      ared  = a17 - 17'sd32768;
      aflip = 1'b1;
    end else if (a17 < -17'sd16384) begin
      ared  = a17 + 17'sd32768;
      aflip = 1'b1;
    end
    zi = {ared, 16'h0000};
  end

  // CORDIC iteration terms
  logic signed [CW-1:0] dx, dy, at, xf, yf;

  always_comb begin
    dx = cy >>> cmd.iter;
    dy = cx >>> cmd.iter;
    at = {2'b00, ATAN_TAB[cmd.iter]};
    xf = flip ? -cx : cx;
    yf = (flip ^ vmode) ? -cy : cy;
  end

  // multiplier operand select
  logic signed [VW-1:0] va;
  logic signed [31:0]   vb;
  logic signed [EW-1:0] ve;
  logic signed [HW-1:0] hi_part;
  logic signed [16:0]   lo_part;
  logic signed [MA-1:0] ma;
  logic signed [PW-1:0] mul_res;

  always_comb begin
    unique case (cmd.mix[2:1])
      2'd0: begin va = vp; vb = cosv; end
      2'd1: begin va = vq; vb = sinv; end
      2'd2: begin va = vq; vb = cosv; end
      2'd3: begin va = vp; vb = sinv; end
    endcase
    ve      = EW'(va);
    hi_part = ve[EW-1:16];
    lo_part = {1'b0, ve[15:0]};
    ma      = cmd.mix[0] ? MA'(lo_part) : MA'(hi_part);
    mul_res = ma * vb;
  end

  logic signed [AW-1:0] pa, psum, pshift;

  always_comb begin
    pa     = AW'(prod);
    psum   = acc + pa;
    pshift = psum >>> 30;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vmode <= mode;
      order <= axis_order;
      ax    <= angle_x;
      ay    <= angle_y;
      az    <= angle_z;
      vx    <= sat_vw(SW'(vec_x));
      vy    <= sat_vw(SW'(vec_y));
      vz    <= sat_vw(SW'(vec_z));
    end

    if (cmd.cinit) begin
      cx   <= {2'b00, CORDIC_GAIN};
      cy   <= '0;
      cz   <= CW'(zi);
      flip <= aflip;
    end else if (cmd.citer) begin
      if (!cz[CW-1]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end
    end

    if (cmd.cfin) begin
      cosv <= xf[31:0];
      sinv <= yf[31:0];
      unique case (code)
        AXIS_X:   begin vp <= vy; vq <= vz; end
        AXIS_Y:   begin vp <= vz; vq <= vx; end
        AXIS_Z:   begin vp <= vx; vq <= vy; end
        AXIS_END: begin vp <= vx; vq <= vy; end
      endcase
    end

    if (cmd.mul) begin
      prod <= mul_res;
      ptag <= cmd.mix;
    end

    if (pvld) begin
      if (!ptag[0]) begin
        acc <= (pa <<< 16) + RND_HALF;
      end else begin
        rnd  <= pshift[RW-1:0];
        rtag <= ptag[2:1];
      end
    end

    if (rvld) begin
      unique case (rtag)
        2'd0: np <= SW'(rnd);
        2'd1: np <= np + SW'(rnd);
        2'd2: nq <= SW'(rnd);
        2'd3: nq <= nq - SW'(rnd);
      endcase
    end

    if (cmd.wb) begin
      unique case (code)
        AXIS_X:   begin vy <= sat_vw(np); vz <= sat_vw(nq); end
        AXIS_Y:   begin vz <= sat_vw(np); vx <= sat_vw(nq); end
        AXIS_Z:   begin vx <= sat_vw(np); vy <= sat_vw(nq); end
        AXIS_END: begin end
      endcase
    end

    if (cmd.rload) begin
      out_x         <= sat_out(vx);
      out_y         <= sat_out(vy);
      out_z         <= sat_out(vz);
      steps_applied <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
      rvld <= 1'b0;
    end else begin
      pvld <= cmd.mul;
      rvld <= pvld && ptag[0];
    end
  end

endmodule

`default_nettype wire

[rtl/euler_axis_rotation_sequence.sv]
// A new item is taken only once the previous result has been posted to the
//   output register; each rotation runs through the serial CORDIC and the
//   single shared multiplier (8 partial products per step).
// Reset clears the sequencer and the output valid; data registers are not reset.
// ----------------------------------------------------------------------------
// euler_axis_rotation_sequence
// Applies up to three single-axis rotations to a Q16.16 vector.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_axis_rotation_sequence import ears_pkg::*; #(
  parameter int MAX_STEPS         = EARS_DEF_MAX_STEPS,
  parameter int CORDIC_ITERATIONS = EARS_DEF_CORDIC_ITER,
  parameter int VECTOR_WIDTH      = EARS_DEF_VECTOR_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode,
  input  wire logic signed [31:0] vec_x,
  input  wire logic signed [31:0] vec_y,
  input  wire logic signed [31:0] vec_z,
  input  wire logic signed [15:0] angle_x,
  input  wire logic signed [15:0] angle_y,
  input  wire logic signed [15:0] angle_z,
  input  wire logic [5:0]         axis_order,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [1:0]              steps_applied
);

  ears_cmd_t    cmd;
  ears_status_t status;

  ears_ctrl #(
    .MAX_STEPS         (MAX_STEPS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  ears_dp #(
    .VECTOR_WIDTH (VECTOR_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .vec_x         (vec_x),
    .vec_y         (vec_y),
    .vec_z         (vec_z),
    .angle_x       (angle_x),
    .angle_y       (angle_y),
    .angle_z       (angle_z),
    .axis_order    (axis_order),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .steps_applied (steps_applied)
  );

endmodule

`default_nettype wire

[rtl/ears_checker.sv]
// ----------------------------------------------------------------------------
// ears_checker
// Port-level checks of the rotation sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "euler_axis_rotation_sequence_defines.svh"

module ears_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_x,
  input wire logic [31:0] out_y,
  input wire logic [31:0] out_z,
  input wire logic [1:0]  steps_applied
);

  // one item in flight: a transfer in closes the input
  `EARS_ASSERT_NEXT(a_accept_blocks, clk, rst, in_valid && !in_stall, in_stall, "input open after transfer")

  // reopening the input only happens with a result posted
  `EARS_ASSERT_NOW(a_reopen_has_result, clk, rst, $fell(in_stall) && !$past(rst), out_valid, "input reopened without result")

  // a new result is posted only while the input is closed
  `EARS_ASSERT_NOW(a_result_while_busy, clk, rst, $rose(out_valid), $past(in_stall), "result posted while idle")

  // stalled result holds
  `EARS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(steps_applied), "stalled result changed")

endmodule

bind euler_axis_rotation_sequence ears_checker u_ears_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_x         (out_x),
  .out_y         (out_y),
  .out_z         (out_z),
  .steps_applied (steps_applied)
);

`default_nettype wire

[sim/euler_axis_rotation_sequence_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_axis_rotation_sequence_test
// Self-checking bench for the Euler axis rotation sequencer. A bit-exact
// CORDIC and rotation predictor computes each expected output vector. A
// scoreboard checks every output transfer in order. Random gaps and output
// stalls are applied on both sides.
// ----------------------------------------------------------------------------
module euler_axis_rotation_sequence_test;
  import ears_pkg::*;

  localparam int      RANDOM_ITEMS = 1200;
  localparam int      DRAIN_CYCLES = 200;
  localparam int      MAX_PRINTED  = 100;
  localparam longint  QUARTER_TURN = 16384;
  localparam longint  HALF_TURN    = 32768;
  localparam longint  COMP_MAX     = 64'sd2147483647;
  localparam longint  COMP_MIN     = -64'sd2147483648;

  localparam logic signed [15:0] EDGE_ANGLES [8] = '{
    16'sh0000, 16'sh4000, 16'shC000, 16'sh4001,
    16'shBFFF, 16'sh7FFF, 16'sh8000, 16'sh2000
  };

  typedef struct {
    logic               mode;
    logic signed [31:0] vx, vy, vz;
    logic signed [15:0] ax, ay, az;
    logic [5:0]         order;
  } rot_request_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [1:0]         steps;
  } rot_result_t;

  class rotation_scoreboard;
    rot_result_t expected_q[$];
    int fail_count;
    int printed;

    function new();
      fail_count = 0;
      printed = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function longint sat32(longint v);
      if (v > COMP_MAX) return COMP_MAX;
      if (v < COMP_MIN) return COMP_MIN;
      return v;
    endfunction

    // round(v * c / 2^30), c in Q2.30
    function longint mul_q30(longint v, longint c);
      return (v * c + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function void cordic_sin_cos(input logic signed [15:0] ang,
                                 output longint cs, output longint sn);
      longint a, x, y, z, dx, dy;
      bit flip;
      int i;
      a = ang;
      flip = 1'b0;
      if (a > QUARTER_TURN) begin
        a -= HALF_TURN;
        flip = 1'b1;
      end else if (a < -QUARTER_TURN) begin
        a += HALF_TURN;
        flip = 1'b1;
      end
      x = longint'(CORDIC_GAIN);
      y = 0;
      z = a * 65536;
      for (i = 0; i < EARS_DEF_CORDIC_ITER; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'(ATAN_TAB[i]);
        end else begin
          x += dx;
          y -= dy;
          z += longint'(ATAN_TAB[i]);
        end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
    endfunction

    function rot_result_t rotate(rot_request_t r);
      longint v [3];
      logic signed [15:0] ang [3];
      longint c, s, np, nq;
      int p, q, k, done;
      axis_code_t code;
      rot_result_t res;
      v[0] = r.vx;
      v[1] = r.vy;
      v[2] = r.vz;
      ang[0] = r.ax;
      ang[1] = r.ay;
      ang[2] = r.az;
      done = 0;
      for (k = 0; k < 3 && k < EARS_DEF_MAX_STEPS; k++) begin
        code = axis_code_t'(r.order[2*k +: 2]);
        if (code == AXIS_END) break;
        cordic_sin_cos(ang[int'(code)], c, s);
        if (r.mode) s = -s;
        case (code)
          AXIS_X: begin p = 1; q = 2; end
          AXIS_Y: begin p = 2; q = 0; end
          default: begin p = 0; q = 1; end
        endcase
        np = mul_q30(v[p], c) + mul_q30(v[q], s);
        nq = mul_q30(v[q], c) - mul_q30(v[p], s);
        v[p] = sat32(np);
        v[q] = sat32(nq);
        done++;
      end
      res.x = v[0][31:0];
      res.y = v[1][31:0];
      res.z = v[2][31:0];
      res.steps = done[1:0];
      return res;
    endfunction

    function void note_request(rot_request_t r);
      expected_q.push_back(rotate(r));
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      if (printed < MAX_PRINTED) begin
        $display("[%0t] mismatch: %s", $time, msg);
        printed++;
        if (printed == MAX_PRINTED)
          $display("further mismatches not shown");
      end
    endtask

    task check_result(rot_result_t got);
      rot_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer x=%0d y=%0d z=%0d steps=%0d",
                                  got.x, got.y, got.z, got.steps));
        return;
      end
      want = expected_q.pop_front();
      if (got.x !== want.x)
        report_mismatch($sformatf("out_x got %0d want %0d", got.x, want.x));
      if (got.y !== want.y)
        report_mismatch($sformatf("out_y got %0d want %0d", got.y, want.y));
      if (got.z !== want.z)
        report_mismatch($sformatf("out_z got %0d want %0d", got.z, want.z));
      if (got.steps !== want.steps)
        report_mismatch($sformatf("steps_applied got %0d want %0d", got.steps, want.steps));
    endtask

    task flush_check();
      rot_result_t want;
      while (expected_q.size() > 0) begin
        want = expected_q.pop_front();
        report_mismatch($sformatf("missing transfer x=%0d y=%0d z=%0d steps=%0d",
                                  want.x, want.y, want.z, want.steps));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic signed [15:0] angle_x = '0;
  logic signed [15:0] angle_y = '0;
  logic signed [15:0] angle_z = '0;
  logic [5:0]         axis_order = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [1:0]         steps_applied;

  rotation_scoreboard sb = new();
  int burst_left = 0;
  int stall_hold = 0;

  euler_axis_rotation_sequence u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .vec_x         (vec_x),
    .vec_y         (vec_y),
    .vec_z         (vec_z),
    .angle_x       (angle_x),
    .angle_y       (angle_y),
    .angle_z       (angle_z),
    .axis_order    (axis_order),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .steps_applied (steps_applied)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_request(rot_request_t'{mode, vec_x, vec_y, vec_z,
                                     angle_x, angle_y, angle_z, axis_order});
    if (!rst && out_valid && !out_stall)
      sb.check_result(rot_result_t'{out_x, out_y, out_z, steps_applied});
  end

  // output backpressure: quiet stretches, short stalls, occasional long ones
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 9))
        0: begin out_stall <= 1'b0; stall_hold <= $urandom_range(100, 300); end
        1, 2, 3, 4: begin out_stall <= 1'b0; stall_hold <= $urandom_range(1, 30); end
        5, 6, 7, 8: begin out_stall <= 1'b1; stall_hold <= $urandom_range(0, 3); end
        default: begin out_stall <= 1'b1; stall_hold <= $urandom_range(10, 60); end
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [5:0] pack_order(axis_code_t a, axis_code_t b, axis_code_t c);
    return {c, b, a};
  endfunction

  function automatic rot_request_t make_request(logic m, logic signed [31:0] x,
      logic signed [31:0] y, logic signed [31:0] z, logic signed [15:0] ax,
      logic signed [15:0] ay, logic signed [15:0] az, logic [5:0] order);
    return rot_request_t'{m, x, y, z, ax, ay, az, order};
  endfunction

  function automatic logic signed [31:0] random_component();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 8) return int'($urandom_range(0, 2097151)) - 1048576;
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic signed [15:0] random_angle();
    if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 65535));
    return EDGE_ANGLES[3'($urandom_range(0, 7))];
  endfunction

  function automatic rot_request_t random_request();
    rot_request_t r;
    r.mode = 1'($urandom_range(0, 1));
    r.vx = random_component();
    r.vy = random_component();
    r.vz = random_component();
    r.ax = random_angle();
    r.ay = random_angle();
    r.az = random_angle();
    if ($urandom_range(0, 9) < 6)
      r.order = pack_order(axis_code_t'($urandom_range(0, 2)),
                           axis_code_t'($urandom_range(0, 2)),
                           axis_code_t'($urandom_range(0, 2)));
    else
      r.order = 6'($urandom_range(0, 63));
    return r;
  endfunction

  task automatic send_request(input rot_request_t r, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= r.mode;
    vec_x      <= r.vx;
    vec_y      <= r.vy;
    vec_z      <= r.vz;
    angle_x    <= r.ax;
    angle_y    <= r.ay;
    angle_z    <= r.az;
    axis_order <= r.order;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    rot_request_t directed [$];
    logic signed [31:0] u1, u2, u3, vmax, vmin;
    u1 = 32'sh0001_0000;
    u2 = 32'sh0002_0000;
    u3 = 32'sh0003_0000;
    vmax = 32'sh7FFF_FFFF;
    vmin = 32'sh8000_0000;

    // sequence ends at once
    directed.push_back(make_request(1'b0, vmax, vmin, -32'sd1, 16'sh2000, 16'sh4000,
                                    16'sh8000, pack_order(AXIS_END, AXIS_X, AXIS_Y)));
    directed.push_back(make_request(1'b1, vmin, vmax, 32'sd0, 16'sh7FFF, 16'sh0,
                                    16'sh0, 6'b111111));
    // single axes, both modes
    directed.push_back(make_request(1'b0, u1, u2, u3, 16'sh2000, 16'sh2000, 16'sh2000,
                                    pack_order(AXIS_X, AXIS_END, AXIS_END)));
    directed.push_back(make_request(1'b0, u1, u2, u3, 16'sh2000, 16'sh2000, 16'sh2000,
                                    pack_order(AXIS_Y, AXIS_END, AXIS_END)));
    directed.push_back(make_request(1'b0, u1, u2, u3, 16'sh2000, 16'sh2000, 16'sh2000,
                                    pack_order(AXIS_Z, AXIS_END, AXIS_END)));
    directed.push_back(make_request(1'b1, u1, u2, u3, 16'sh2000, 16'sh2000, 16'sh2000,
                                    pack_order(AXIS_X, AXIS_END, AXIS_END)));
    directed.push_back(make_request(1'b1, u1, u2, u3, 16'sh2000, 16'sh2000, 16'sh2000,
                                    pack_order(AXIS_Y, AXIS_END, AXIS_END)));
    directed.push_back(make_request(1'b1, u1, u2, u3, 16'sh2000, 16'sh2000, 16'sh2000,
                                    pack_order(AXIS_Z, AXIS_END, AXIS_END)));
    // angle folding around +-pi/2 and the ends of the range
    directed.push_back(make_request(1'b0, u3, u2, u1, 16'sh4000, 16'shC000, 16'sh4001,
                                    pack_order(AXIS_X, AXIS_Y, AXIS_Z)));
    directed.push_back(make_request(1'b1, u3, u2, u1, 16'shBFFF, 16'sh7FFF, 16'sh8000,
                                    pack_order(AXIS_X, AXIS_Y, AXIS_Z)));
    directed.push_back(make_request(1'b0, u1, -u2, u3, 16'sh8000, 16'sh7FFF, 16'sh0,
                                    pack_order(AXIS_Z, AXIS_Y, AXIS_X)));
    directed.push_back(make_request(1'b1, -u1, u2, -u3, 16'sh0, 16'shFFFF, 16'sh0001,
                                    pack_order(AXIS_Z, AXIS_Y, AXIS_X)));
    // end code after one and two steps
    directed.push_back(make_request(1'b0, u1, u2, u3, 16'sh1000, 16'sh3000, 16'shE000,
                                    pack_order(AXIS_X, AXIS_END, AXIS_Y)));
    directed.push_back(make_request(1'b1, u1, u2, u3, 16'sh1000, 16'sh3000, 16'shE000,
                                    pack_order(AXIS_Y, AXIS_Z, AXIS_END)));
    // repeated axis
    directed.push_back(make_request(1'b0, u2, u3, u1, 16'sh2AAB, 16'sh0, 16'sh0,
                                    pack_order(AXIS_X, AXIS_X, AXIS_X)));
    // saturation at both limits
    directed.push_back(make_request(1'b0, vmax, vmax, vmax, 16'sh2000, 16'sh2000, 16'sh2000,
                                    pack_order(AXIS_Z, AXIS_X, AXIS_Y)));
    directed.push_back(make_request(1'b1, vmin, vmin, vmin, 16'shE000, 16'shE000, 16'shE000,
                                    pack_order(AXIS_Z, AXIS_X, AXIS_Y)));
    directed.push_back(make_request(1'b0, vmin, vmax, vmin, 16'sh8000, 16'sh6000, 16'shA000,
                                    pack_order(AXIS_Y, AXIS_X, AXIS_Z)));
    directed.push_back(make_request(1'b1, vmax, vmin, vmax, 16'sh2000, 16'shE000, 16'sh2000,
                                    pack_order(AXIS_Y, AXIS_Z, AXIS_X)));
    // zero and plus/minus one LSB
    directed.push_back(make_request(1'b0, 32'sd0, 32'sd0, 32'sd0, 16'sh7FFF, 16'sh8000,
                                    16'sh4000, pack_order(AXIS_X, AXIS_Y, AXIS_Z)));
    directed.push_back(make_request(1'b1, -32'sd1, -32'sd1, -32'sd1, 16'sh2000, 16'sh2000,
                                    16'sh2000, pack_order(AXIS_X, AXIS_Y, AXIS_Z)));
    directed.push_back(make_request(1'b0, 32'sd1, -32'sd1, 32'sd1, 16'sh0, 16'sh0, 16'sh0,
                                    pack_order(AXIS_Z, AXIS_Z, AXIS_Z)));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_request(directed[i], pick_gap());
    repeat (RANDOM_ITEMS)
      send_request(random_request(), pick_gap());
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flush_check();
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
